### design/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ISP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ISP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/isp_pkg.sv
// Shared types, codes and the precedence function of the infix-to-postfix converter.
package isp_pkg;

    localparam int CMD_W  = 3;
    localparam int NUM_W  = 32;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;

    localparam logic [CMD_W-1:0] CMD_NUMBER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ADD  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_OPEN = 8'h28;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CHAR_W-1:0] data;
    } t_stk_ctl;

    function automatic logic [1:0] rank_of(input logic [CHAR_W-1:0] ch);
        logic [1:0] r;
        if (ch == CH_MUL || ch == CH_DIV) begin
            r = 2'd2;
        end else if (ch == CH_ADD || ch == CH_SUB) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

### design/infix_to_postfix_converter_core.sv
// Top level of the shunting-yard infix-to-postfix converter.
// One token request is taken at a time and the input stalls until it is done.
// A number goes straight to the output, an open parenthesis is pushed, an
// operator pops each entry of equal or higher rank and is then pushed, a close
// parenthesis pops entries up to its open parenthesis, and end pops every entry
// left on the stack before an end result. The operator stack is a row of
// STACK_DEPTH shifting cells that moves one entry per push or pop, and results leave through a single
// output register that keeps its result while the sink stalls.
// There is no clearing pass after reset; the entry count starts at zero.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [isp_pkg::CMD_W-1:0]   i_cmd,
    input  logic [isp_pkg::NUM_W-1:0]   i_number_value,
    input  logic [isp_pkg::CHAR_W-1:0]  i_op_char,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [isp_pkg::KIND_W-1:0]  o_out_kind,
    output logic [isp_pkg::NUM_W-1:0]   o_out_number,
    output logic [isp_pkg::CHAR_W-1:0]  o_out_char,
    output logic                        o_overflow,
    output logic                        o_last
);
    import isp_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic              r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [CHAR_W-1:0] r_char, n_char;

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [NUM_W-1:0]  r_onum, n_onum;
    logic [CHAR_W-1:0] r_ochar, n_ochar;
    logic              r_ovf, n_ovf;
    logic              r_last, n_last;

    t_stk_ctl          w_ctl;
    logic [CHAR_W-1:0] w_top;
    logic [CHAR_W-1:0] w_next;
    logic              w_accept;
    logic              w_slot_free;
    logic              w_empty;
    logic              w_full;
    logic [1:0]        w_rank;
    logic              w_pop_op;

    isp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_top  (w_top),
        .o_next (w_next)
    );

    assign o_in_stall  = (r_state == S_BUSY);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_FULL);
    assign w_rank      = rank_of(r_char);
    assign w_pop_op    = !w_empty && (w_rank <= rank_of(w_top));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_num       = r_num;
        n_char      = r_char;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_onum      = r_onum;
        n_ochar     = r_ochar;
        n_ovf       = r_ovf;
        n_last      = r_last;
        w_ctl       = '0;

        if (w_accept) begin
            n_state = S_BUSY;
            n_cmd   = i_cmd;
            n_num   = i_number_value;
            n_char  = i_op_char;
        end

        if (r_state == S_BUSY) begin
            unique case (r_cmd)
                CMD_NUMBER: begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_NUMBER;
                        n_onum      = r_num;
                        n_ochar     = '0;
                        n_ovf       = 1'b0;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
                CMD_OPEN: begin
                    if (!w_full) begin
                        w_ctl.push = 1'b1;
                        w_ctl.data = CH_OPEN;
                        n_count    = r_count + CNT_ONE;
                        n_state    = S_IDLE;
                    end else if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_CHAR;
                        n_onum      = '0;
                        n_ochar     = CH_OPEN;
                        n_ovf       = 1'b1;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
                CMD_CLOSE: begin
                    if (w_empty) begin
                        n_state = S_IDLE;
                    end else if (w_top == CH_OPEN) begin
                        w_ctl.pop = 1'b1;
                        n_count   = r_count - CNT_ONE;
                        n_state   = S_IDLE;
                    end else if (w_slot_free) begin
                        w_ctl.pop   = 1'b1;
                        n_count     = r_count - CNT_ONE;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_CHAR;
                        n_onum      = '0;
                        n_ochar     = w_top;
                        n_ovf       = 1'b0;
                        n_last      = (r_count == CNT_ONE) || (w_next == CH_OPEN);
                    end
                end
                CMD_OP: begin
                    if (w_pop_op) begin
                        if (w_slot_free) begin
                            w_ctl.pop   = 1'b1;
                            n_count     = r_count - CNT_ONE;
                            n_out_valid = 1'b1;
                            n_kind      = KIND_CHAR;
                            n_onum      = '0;
                            n_ochar     = w_top;
                            n_ovf       = 1'b0;
                            n_last      = !((r_count > CNT_ONE)
                                            && (w_rank <= rank_of(w_next)));
                        end
                    end else if (!w_full) begin
                        w_ctl.push = 1'b1;
                        w_ctl.data = r_char;
                        n_count    = r_count + CNT_ONE;
                        n_state    = S_IDLE;
                    end else if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_CHAR;
                        n_onum      = '0;
                        n_ochar     = r_char;
                        n_ovf       = 1'b1;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
                CMD_END: begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_onum      = '0;
                        n_ovf       = 1'b0;
                        if (!w_empty) begin
                            w_ctl.pop = 1'b1;
                            n_count   = r_count - CNT_ONE;
                            n_kind    = KIND_CHAR;
                            n_ochar   = w_top;
                            n_last    = 1'b0;
                        end else begin
                            n_kind  = KIND_END;
                            n_ochar = '0;
                            n_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_num   <= n_num;
        r_char  <= n_char;
        r_kind  <= n_kind;
        r_onum  <= n_onum;
        r_ochar <= n_ochar;
        r_ovf   <= n_ovf;
        r_last  <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_kind;
    assign o_out_number = r_onum;
    assign o_out_char   = r_ochar;
    assign o_overflow   = r_ovf;
    assign o_last       = r_last;

    `ISP_ASSERT(a_no_push_and_pop, i_clk, i_rst_n, !(w_ctl.push && w_ctl.pop), "push and pop together")
    `ISP_ASSERT(a_pop_needs_entry, i_clk, i_rst_n, w_ctl.pop |-> !w_empty, "pop from empty stack")
    `ISP_ASSERT(a_push_needs_room, i_clk, i_rst_n, w_ctl.push |-> !w_full, "push onto full stack")
    `ISP_ASSERT(a_count_bounded, i_clk, i_rst_n, r_count <= CNT_FULL, "entry count out of range")
    `ISP_ASSERT(a_end_or_ovf_is_last, i_clk, i_rst_n, (r_out_valid && (r_ovf || r_kind == KIND_END)) |-> r_last, "end or overflow result not marked last")

endmodule

### design/isp_cell.sv
// One operator stack cell: takes its upper neighbor on push, its lower neighbor on pop.
module isp_cell (
    input  logic                      i_clk,
    input  isp_pkg::t_stk_ctl         i_ctl,
    input  logic [isp_pkg::CHAR_W-1:0] i_upper,
    input  logic [isp_pkg::CHAR_W-1:0] i_lower,
    output logic [isp_pkg::CHAR_W-1:0] o_data
);
    import isp_pkg::*;

    logic [CHAR_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_upper;
        end else if (i_ctl.pop) begin
            r_data <= i_lower;
        end
    end

    assign o_data = r_data;

endmodule

### design/isp_stack.sv
// Operator stack as a shifting row of cells; cell 0 is the top of stack.
module isp_stack #(
    parameter int DEPTH = 32
) (
    input  logic                      i_clk,
    input  isp_pkg::t_stk_ctl         i_ctl,
    output logic [isp_pkg::CHAR_W-1:0] o_top,
    output logic [isp_pkg::CHAR_W-1:0] o_next
);
    import isp_pkg::*;

    logic [CHAR_W-1:0] w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [CHAR_W-1:0] w_upper;
        logic [CHAR_W-1:0] w_lower;

        if (g == 0) begin : g_first
            assign w_upper = i_ctl.data;
        end else begin : g_mid
            assign w_upper = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_lower = '0;
        end else begin : g_inner
            assign w_lower = w_cell[g+1];
        end

        isp_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_upper (w_upper),
            .i_lower (w_lower),
            .o_data  (w_cell[g])
        );
    end

    assign o_top  = w_cell[0];
    assign o_next = w_cell[1];

endmodule
